FILE: src/mrc_pkg.sv
// Shared types, constants and the CRC-16 byte step for the Modbus RTU response checker.
// No dependencies; every other file imports this package.
`timescale 1ns / 1ps

package mrc_pkg;

    localparam int BYTE_W = 8;
    localparam int LEN_W  = 9;

    // Largest frame the length counter tracks before it saturates.
    localparam int MAX_FRAME_BYTES_DEF = 256;

    localparam logic [15:0]       CRC_START = 16'hFFFF;
    localparam logic [15:0]       CRC_POLY  = 16'hA001;
    localparam logic [BYTE_W-1:0] EXC_FLAG  = 8'h80;
    localparam logic [LEN_W-1:0]  MIN_FRAME = 9'd4;

    // Exception codes carried in the byte after an exception function code.
    localparam logic [BYTE_W-1:0] EXC_ILL_FUNC = 8'd1;
    localparam logic [BYTE_W-1:0] EXC_ILL_ADDR = 8'd2;
    localparam logic [BYTE_W-1:0] EXC_ILL_VAL  = 8'd3;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_COMM     = 3'd1,
        ST_ILL_FUNC = 3'd2,
        ST_ILL_ADDR = 3'd3,
        ST_ILL_VAL  = 3'd4
    } status_t;

    typedef struct packed {
        logic [BYTE_W-1:0] rx_byte;
        logic              frame_end;
        logic [BYTE_W-1:0] expected_function;
    } rx_word_t;

    typedef struct packed {
        logic     valid;
        rx_word_t word;
    } stage_t;

    typedef struct packed {
        status_t          status;
        logic [LEN_W-1:0] frame_length;
    } rsp_word_t;

    // One byte through the reflected CRC-16, eight shift steps unrolled.
    function automatic logic [15:0] crc_absorb(logic [15:0] crc, logic [BYTE_W-1:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int k = 0; k < 8; k++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

FILE: src/mrc_if.sv
// Valid/ready channel interfaces for received bytes and for frame results.
// Depends on mrc_pkg for the field widths.
`timescale 1ns / 1ps

interface mrc_rx_if import mrc_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] rx_byte;
    logic              frame_end;
    logic [BYTE_W-1:0] expected_function;

    modport source (output valid, rx_byte, frame_end, expected_function, input ready);
    modport sink   (input valid, rx_byte, frame_end, expected_function, output ready);
endinterface

interface mrc_rsp_if import mrc_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [2:0]       status;
    logic [LEN_W-1:0] frame_length;

    modport source (output valid, status, frame_length, input ready);
    modport sink   (input valid, status, frame_length, output ready);
endinterface

FILE: src/mrc_in_reg.sv
// Input register: holds one received word until the frame logic takes it.
// Depends on mrc_pkg and mrc_rx_if.
`timescale 1ns / 1ps

module mrc_in_reg import mrc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    mrc_rx_if.sink     rx,
    input  logic       advance,
    output stage_t     stage
);

    logic     valid_reg;
    rx_word_t word_reg;
    logic     take_in;

    // The register refills in the same cycle that its word moves on.
    assign rx.ready = !valid_reg || advance;
    assign take_in  = rx.valid && rx.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (rx.ready)
        begin
            valid_reg <= rx.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take_in)
        begin
            word_reg <= '{rx_byte: rx.rx_byte, frame_end: rx.frame_end,
                          expected_function: rx.expected_function};
        end
    end

    assign stage = '{valid: valid_reg, word: word_reg};

endmodule

FILE: src/mrc_frame_check.sv
// Frame state (CRC, two-byte delay line, count, captured bytes) and the final decision.
// Depends on mrc_pkg.
`timescale 1ns / 1ps

module mrc_frame_check import mrc_pkg::*;
#(
    parameter int MAX_FRAME_BYTES = MAX_FRAME_BYTES_DEF
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  stage_t    stage,
    input  logic      take,
    output logic      result_valid,
    output rsp_word_t result
);

    logic [15:0]       crc_reg, crc_next;
    logic [BYTE_W-1:0] held0_reg, held0_next;
    logic [BYTE_W-1:0] held1_reg, held1_next;
    logic [LEN_W-1:0]  count_reg, count_next;
    logic [BYTE_W-1:0] func_reg, func_next;
    logic [BYTE_W-1:0] exc_reg, exc_next;

    logic [15:0]       crc_upd;
    logic [LEN_W-1:0]  count_inc;
    logic [BYTE_W-1:0] exc_fn;
    status_t           status;

    // A byte enters the CRC only as it leaves the delay line, so the last two
    // bytes of the frame are left out and compared against the CRC instead.
    assign crc_upd   = (count_reg >= 9'd2) ? crc_absorb(crc_reg, held0_reg) : crc_reg;
    assign count_inc = (count_reg < LEN_W'(MAX_FRAME_BYTES)) ? count_reg + 9'd1 : count_reg;
    assign exc_fn    = stage.word.expected_function + EXC_FLAG;

    always_comb
    begin
        if (count_inc < MIN_FRAME)
        begin
            status = ST_COMM;
        end
        else if (crc_upd[7:0] != held1_reg || crc_upd[15:8] != stage.word.rx_byte)
        begin
            status = ST_COMM;
        end
        else if (func_reg == exc_fn)
        begin
            case (exc_reg)
                EXC_ILL_FUNC: status = ST_ILL_FUNC;
                EXC_ILL_ADDR: status = ST_ILL_ADDR;
                EXC_ILL_VAL:  status = ST_ILL_VAL;
                default:      status = ST_COMM;
            endcase
        end
        else
        begin
            status = ST_OK;
        end
    end

    assign result_valid = take && stage.word.frame_end;
    assign result       = '{status: status, frame_length: count_inc};

    always_comb
    begin
        crc_next   = crc_reg;
        held0_next = held0_reg;
        held1_next = held1_reg;
        count_next = count_reg;
        func_next  = func_reg;
        exc_next   = exc_reg;
        if (take)
        begin
            if (stage.word.frame_end)
            begin
                crc_next   = CRC_START;
                held0_next = '0;
                held1_next = '0;
                count_next = '0;
                func_next  = '0;
                exc_next   = '0;
            end
            else
            begin
                crc_next   = crc_upd;
                held0_next = held1_reg;
                held1_next = stage.word.rx_byte;
                count_next = count_inc;
                if (count_reg == 9'd1)
                begin
                    func_next = stage.word.rx_byte;
                end
                if (count_reg == 9'd2)
                begin
                    exc_next = stage.word.rx_byte;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            crc_reg   <= CRC_START;
            held0_reg <= '0;
            held1_reg <= '0;
            count_reg <= '0;
            func_reg  <= '0;
            exc_reg   <= '0;
        end
        else
        begin
            crc_reg   <= crc_next;
            held0_reg <= held0_next;
            held1_reg <= held1_next;
            count_reg <= count_next;
            func_reg  <= func_next;
            exc_reg   <= exc_next;
        end
    end

endmodule

FILE: src/mrc_out_reg.sv
// Result register: holds one frame result until the sink takes it.
// Depends on mrc_pkg and mrc_rsp_if.
`timescale 1ns / 1ps

module mrc_out_reg import mrc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       load,
    input  rsp_word_t  result,
    output logic       free,
    mrc_rsp_if.source  rsp
);

    logic      valid_reg;
    rsp_word_t data_reg;

    assign free = !valid_reg || rsp.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (load)
        begin
            valid_reg <= 1'b1;
        end
        else if (rsp.ready)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= result;
        end
    end

    assign rsp.valid        = valid_reg;
    assign rsp.status       = data_reg.status;
    assign rsp.frame_length = data_reg.frame_length;

endmodule

FILE: src/modbus_rtu_response_checker.sv
// Top level of the Modbus RTU response checker: input register, frame logic, result register.
// Depends on mrc_pkg, mrc_if, mrc_in_reg, mrc_frame_check and mrc_out_reg.
//
//   Channel | Dir | Fields                                   | Words
//   --------+-----+------------------------------------------+---------------------------
//   rx      | in  | rx_byte[7:0], frame_end, expected_function[7:0] | one per frame byte
//   rsp     | out | status[2:0], frame_length[8:0]          | one per word with frame_end
//
// A new word is accepted every cycle unless a last word waits on a stalled rsp. The limit is the
// single combinational pass from the input register to the result register: the
// unrolled eight-step CRC byte update, then the CRC compare and status decision.
// A result is loaded into the result register when its last word leaves the input register,
// and the sink takes it from there on rsp.
// Reset (rst_n low, asynchronous) empties both registers and sets the CRC to 0xFFFF,
// the delay line, count and captured bytes to zero. When rsp stalls with a result
// held, words that are not last keep flowing; a last word waits in the input register.
`timescale 1ns / 1ps

module modbus_rtu_response_checker import mrc_pkg::*;
#(
    parameter int MAX_FRAME_BYTES = MAX_FRAME_BYTES_DEF
)
(
    input  logic      clk,
    input  logic      rst_n,
    mrc_rx_if.sink    rx,
    mrc_rsp_if.source rsp
);

    stage_t    stage;
    rsp_word_t result;
    logic      result_valid;
    logic      out_free;
    logic      advance;
    logic      take;

    // A word that is not last never produces a result, so it may always move
    // into the frame logic. A last word moves only when the result register
    // can take its result in the same edge.
    assign advance = !stage.word.frame_end || out_free;
    assign take    = stage.valid && advance;

    mrc_in_reg u_in_reg (
        .clk     (clk),
        .rst_n   (rst_n),
        .rx      (rx),
        .advance (advance),
        .stage   (stage)
    );

    // Running CRC over all but the final two bytes, the two-byte delay line,
    // the saturating byte count and the function and exception captures. On a
    // last word the decision is made and all of that returns to reset values.
    mrc_frame_check #(
        .MAX_FRAME_BYTES (MAX_FRAME_BYTES)
    ) u_frame_check (
        .clk          (clk),
        .rst_n        (rst_n),
        .stage        (stage),
        .take         (take),
        .result_valid (result_valid),
        .result       (result)
    );

    mrc_out_reg u_out_reg (
        .clk    (clk),
        .rst_n  (rst_n),
        .load   (result_valid),
        .result (result),
        .free   (out_free),
        .rsp    (rsp)
    );

`ifndef SYNTHESIS
    // A fresh result only ever follows a last word leaving the input register.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp.valid) |-> $past(stage.valid && stage.word.frame_end))
    else $error("result appeared without a last word");

    // The reported length is at least one byte and never above the saturation point.
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid |-> (rsp.frame_length >= 9'd1 &&
                       rsp.frame_length <= LEN_W'(MAX_FRAME_BYTES)))
    else $error("frame length out of range");

    // A frame too short to carry a CRC is always a communication error.
    assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && rsp.frame_length < MIN_FRAME) |-> rsp.status == ST_COMM)
    else $error("short frame not flagged");

    // A last word is never taken while the result register is still full and stalled.
    assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && !rsp.ready) |-> !result_valid)
    else $error("result overwritten while stalled");
`endif

endmodule

FILE: tb/sv/mrc_response_scoreboard.sv
// Frame CRC helper and the scoreboard that predicts and checks every Modbus RTU frame verdict.
// Depends on mrc_pkg and on the mrc_rx_if / mrc_rsp_if channel interfaces.
`timescale 1ns / 1ps

package mrc_frame_crc_pkg;
    import mrc_pkg::*;

    // Reflected CRC-16, fed one data bit at a time, least significant bit first.
    function automatic logic [15:0] crc16_feed(logic [15:0] acc, logic [7:0] data);
        logic [15:0] r;
        logic        fb;
        r = acc;
        for (int i = 0; i < 8; i++)
        begin
            fb = r[0] ^ data[i];
            r  = r >> 1;
            if (fb)
            begin
                r = r ^ CRC_POLY;
            end
        end
        return r;
    endfunction

endpackage

module mrc_response_scoreboard
    import mrc_pkg::*;
    import mrc_frame_crc_pkg::*;
#(
    parameter int MAX_BYTES = MAX_FRAME_BYTES_DEF
)
(
    input  logic clk,
    input  logic rst_n,
    mrc_rx_if    rx,
    mrc_rsp_if   rsp,
    output int   mismatches,
    output int   verdicts_owed
);

    // Shadow of the frame state: CRC over bytes that left the two-byte delay line.
    logic [15:0]      crc_acc;
    logic [7:0]       delay_q [2];
    logic [LEN_W-1:0] seen;
    logic [7:0]       fn_cap;
    logic [7:0]       code_cap;

    rsp_word_t owed_q[$];
    int        fail_tally = 0;
    int        owed_now   = 0;

    assign mismatches    = fail_tally;
    assign verdicts_owed = owed_now;

    task automatic report(input string what, input int got, input int want);
        $display("%0t: mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
        fail_tally++;
    endtask

    task automatic clear_frame();
        crc_acc    = CRC_START;
        delay_q[0] = '0;
        delay_q[1] = '0;
        seen       = '0;
        fn_cap     = '0;
        code_cap   = '0;
    endtask

    // Advance the shadow state by one received word and queue a verdict on the last one.
    task automatic absorb_word(input logic [7:0] b, input logic last, input logic [7:0] expf);
        rsp_word_t  v;
        logic [7:0] exc_fn;
        if (seen >= 2)
        begin
            crc_acc = crc16_feed(crc_acc, delay_q[0]);
        end
        delay_q[0] = delay_q[1];
        delay_q[1] = b;
        if (seen == 1)
        begin
            fn_cap = b;
        end
        else if (seen == 2)
        begin
            code_cap = b;
        end
        if (seen < MAX_BYTES)
        begin
            seen = seen + 1'b1;
        end
        if (last)
        begin
            v.frame_length = seen;
            exc_fn         = expf + EXC_FLAG;
            if (seen < MIN_FRAME)
            begin
                v.status = ST_COMM;
            end
            else if (crc_acc[7:0] != delay_q[0] || crc_acc[15:8] != delay_q[1])
            begin
                v.status = ST_COMM;
            end
            else if (fn_cap == exc_fn)
            begin
                case (code_cap)
                    EXC_ILL_FUNC: v.status = ST_ILL_FUNC;
                    EXC_ILL_ADDR: v.status = ST_ILL_ADDR;
                    EXC_ILL_VAL:  v.status = ST_ILL_VAL;
                    default:      v.status = ST_COMM;
                endcase
            end
            else
            begin
                v.status = ST_OK;
            end
            owed_q.push_back(v);
            clear_frame();
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        rsp_word_t v;
        if (!rst_n)
        begin
            clear_frame();
            owed_q.delete();
        end
        else
        begin
            // Results first, so a word taken at this edge can never satisfy a result at it.
            if (rsp.valid && rsp.ready)
            begin
                if (owed_q.size() == 0)
                begin
                    report("result with no frame pending", rsp.status, 0);
                end
                else
                begin
                    v = owed_q.pop_front();
                    if (rsp.status !== v.status)
                    begin
                        report("status", rsp.status, v.status);
                    end
                    if (rsp.frame_length !== v.frame_length)
                    begin
                        report("frame_length", rsp.frame_length, v.frame_length);
                    end
                end
            end
            if (rx.valid && rx.ready)
            begin
                absorb_word(rx.rx_byte, rx.frame_end, rx.expected_function);
            end
        end
        owed_now = owed_q.size();
    end

endmodule

FILE: tb/sv/testbench.sv
// Top of the Modbus RTU response checker testbench: clock, reset, frame stimulus and verdict.
// Depends on mrc_pkg, the channel interfaces, the DUT and mrc_response_scoreboard.
`timescale 1ns / 1ps

module testbench;
    import mrc_pkg::*;
    import mrc_frame_crc_pkg::*;

    // Roughly how many words the whole run sends before the drain starts.
    localparam int TARGET_WORDS = 1300;
    // A last word's result passes through both DUT registers; leave some margin.
    localparam int DRAIN_CYCLES = 8;
    // Longest correct stretch without any handshake is a long sink stall plus a long
    // source gap, far below this limit, so this only trips on a real hang.
    localparam int QUIET_LIMIT  = 2000;

    logic clk;
    logic rst_n;

    mrc_rx_if  rx ();
    mrc_rsp_if rsp ();

    int mismatches;
    int verdicts_owed;

    // The frame being built and then sent, one byte per word.
    logic [7:0] reply[$];

    int src_calm     = 0;
    int snk_calm     = 0;
    int snk_stall    = 0;
    int quiet_cycles = 0;
    int words_sent   = 0;

    modbus_rtu_response_checker uut
    (
        .clk   (clk),
        .rst_n (rst_n),
        .rx    (rx),
        .rsp   (rsp)
    );

    mrc_response_scoreboard u_scoreboard
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .rx            (rx),
        .rsp           (rsp),
        .mismatches    (mismatches),
        .verdicts_owed (verdicts_owed)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Idle length for either side. Most are zero or short, a few are long, and now and
    // then a calm stretch starts during which the side does not idle at all.
    function automatic int idle_gap(inout int calm);
        int roll;
        if (calm > 0)
        begin
            calm--;
            return 0;
        end
        roll = $urandom_range(0, 99);
        if (roll < 2)
        begin
            calm = $urandom_range(40, 200);
            return 0;
        end
        if (roll < 70)
        begin
            return 0;
        end
        if (roll < 90)
        begin
            return $urandom_range(1, 3);
        end
        if (roll < 97)
        begin
            return $urandom_range(4, 8);
        end
        return $urandom_range(12, 40);
    endfunction

    // Append the frame CRC, low byte first, as a Modbus RTU sender does.
    function automatic void seal_reply();
        logic [15:0] acc;
        acc = CRC_START;
        foreach (reply[i])
        begin
            acc = crc16_feed(acc, reply[i]);
        end
        reply.push_back(acc[7:0]);
        reply.push_back(acc[15:8]);
    endfunction

    // Send the frame held in reply. Words change at the falling edge and are taken at the
    // first rising edge with ready high. The expected function only matters on the last
    // word, so the other words carry random values there.
    task automatic send_reply(input logic [7:0] expf);
        int   gap;
        logic last;
        foreach (reply[i])
        begin
            last                 = (i == reply.size() - 1);
            rx.valid             = 1'b1;
            rx.rx_byte           = reply[i];
            rx.frame_end         = last;
            rx.expected_function = last ? expf : 8'($urandom);
            @(posedge clk);
            while (!rx.ready)
            begin
                @(posedge clk);
            end
            @(negedge clk);
            words_sent++;
            gap = idle_gap(src_calm);
            if (gap > 0)
            begin
                // Scramble the payload while valid is low; the DUT must ignore it.
                rx.valid             = 1'b0;
                rx.rx_byte           = 8'($urandom);
                rx.frame_end         = 1'($urandom);
                rx.expected_function = 8'($urandom);
                repeat (gap) @(negedge clk);
            end
        end
    endtask

    // Result side: ready drops for random stalls, with calm stretches in between.
    initial
    begin
        rsp.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (snk_stall > 0)
            begin
                rsp.ready = 1'b0;
                snk_stall--;
            end
            else
            begin
                rsp.ready = 1'b1;
                snk_stall = idle_gap(snk_calm);
            end
        end
    end

    // Any cycle without a handshake on either channel counts toward a hang.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((rx.valid && rx.ready) || (rsp.valid && rsp.ready))
            begin
                quiet_cycles = 0;
            end
            else
            begin
                quiet_cycles++;
            end
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("%0t: no handshake for %0d cycles", $realtime, QUIET_LIMIT);
                $display("simulation failed");
                $finish;
            end
        end
    end

    initial
    begin
        int         frame_no;
        int         long_a;
        int         long_b;
        int         roll;
        int         pick;
        int         body;
        logic [7:0] expf;
        logic [7:0] code;

        rx.valid             = 1'b0;
        rx.rx_byte           = '0;
        rx.frame_end         = 1'b0;
        rx.expected_function = '0;
        rst_n                = 1'b0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed frames.
        // A single byte marked last is a short frame.
        reply = '{8'h01};
        send_reply(8'h03);
        // Three bytes whose trailing CRC is correct are still too short to pass.
        reply = '{8'hFF};
        seal_reply();
        send_reply(8'h03);
        // Smallest good frame; expected function 0xFF wraps to 0x7F for the exception test.
        reply = '{8'h00, 8'h00};
        seal_reply();
        send_reply(8'hFF);
        // Four-byte exception frame: the exception code captured is the CRC low byte.
        reply = '{8'h01, 8'h83};
        seal_reply();
        send_reply(8'h03);
        // Good body with the top bit of the CRC high byte flipped.
        reply = '{8'hFF, 8'hFF};
        seal_reply();
        reply[3] ^= 8'h80;
        send_reply(8'h01);
        // Illegal function exception where expected function plus 0x80 wraps to 0x03.
        reply = '{8'h0A, 8'h03, EXC_ILL_FUNC};
        seal_reply();
        send_reply(8'h83);
        // Illegal value exception without wrap.
        reply = '{8'hF7, 8'h86, EXC_ILL_VAL};
        seal_reply();
        send_reply(8'h06);

        // Random frames. Two of them are long: one exactly at the saturation size and
        // one past it, so the length counter has to hold while the CRC keeps running.
        frame_no = 0;
        long_a   = $urandom_range(5, 40);
        long_b   = $urandom_range(41, 80);
        while (words_sent < TARGET_WORDS)
        begin
            expf = 8'($urandom);
            reply.delete();
            if (frame_no == long_a || frame_no == long_b)
            begin
                body = (frame_no == long_a) ? MAX_FRAME_BYTES_DEF - 2
                                            : $urandom_range(MAX_FRAME_BYTES_DEF - 1,
                                                             MAX_FRAME_BYTES_DEF + 10);
                repeat (body) reply.push_back(8'($urandom));
                seal_reply();
            end
            else
            begin
                roll = $urandom_range(0, 99);
                if (roll < 67)
                begin
                    // Normal reply: address, function, a few data bytes, CRC. The upper
                    // part of this range gets one random bit flipped after sealing.
                    reply.push_back(8'($urandom));
                    reply.push_back(($urandom_range(0, 4) == 0) ? expf : 8'($urandom));
                    repeat ($urandom_range(0, 8)) reply.push_back(8'($urandom));
                    seal_reply();
                    if (roll >= 55)
                    begin
                        pick = $urandom_range(0, reply.size() - 1);
                        reply[pick] ^= 8'(1 << $urandom_range(0, 7));
                    end
                end
                else if (roll < 87)
                begin
                    // Exception reply, mostly with one of the three known codes.
                    pick = $urandom_range(0, 9);
                    if (pick < 6)
                    begin
                        code = 8'($urandom_range(EXC_ILL_FUNC, EXC_ILL_VAL));
                    end
                    else if (pick < 8)
                    begin
                        code = (pick == 6) ? 8'h00 : 8'h04;
                    end
                    else
                    begin
                        code = 8'($urandom);
                    end
                    reply.push_back(8'($urandom));
                    reply.push_back(expf + EXC_FLAG);
                    reply.push_back(code);
                    if ($urandom_range(0, 3) == 0)
                    begin
                        repeat ($urandom_range(1, 3)) reply.push_back(8'($urandom));
                    end
                    seal_reply();
                end
                else if (roll < 95)
                begin
                    repeat ($urandom_range(1, 3)) reply.push_back(8'($urandom));
                end
                else
                begin
                    repeat ($urandom_range(4, 10)) reply.push_back(8'($urandom));
                end
            end
            send_reply(expf);
            frame_no++;
        end
        rx.valid = 1'b0;

        // Let every outstanding verdict come out, then keep the clock running for
        // DRAIN_CYCLES more so a stray extra result would still be caught.
        while (verdicts_owed != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatches == 0)
        begin
            $display("simulation ok");
        end
        else
        begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
